/* rtl/core/chtu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chtu_pkg - shared types for the coalesced hash table unit
// Field widths, result codes, controller states, datapath commands and the
// status bundle that the datapath returns to the controller.
// ----------------------------------------------------------------------------
package chtu_pkg;

  localparam int KEY_W           = 30;
  localparam int STATUS_W        = 3;
  localparam int IDX_W           = 6;
  localparam int S_DATA_W        = 32;
  localparam int M_DATA_W        = 16;
  localparam int DEF_TABLE_SLOTS = 37;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_MOD,
    CS_LK_RD,
    CS_LK_CHK,
    CS_PR_RD,
    CS_PR_CHK,
    CS_CW_RD,
    CS_CW_CHK,
    CS_DONE
  } ctrl_state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_MOD,
    CMD_LK_RD,
    CMD_LK_CHK,
    CMD_PR_RD,
    CMD_PR_CHK,
    CMD_CW_RD,
    CMD_CW_CHK,
    CMD_EMIT
  } dp_cmd_e;

  typedef struct packed {
    logic clr_last;   // clearing pass at last slot
    logic mod_last;   // last remainder step
    logic lk_hit;     // lookup matched current slot
    logic lk_end;     // lookup chain ended without match
    logic op_find;    // request is a find
    logic pr_empty;   // probed slot is free
    logic pr_home;    // probed slot is the home slot
    logic pr_last;    // probe reached the last offset
    logic cw_end;     // chain walk reached the tail
    logic out_busy;   // output register cannot take a result
  } dp_stat_t;

endpackage
`default_nettype wire

/* rtl/core/chtu_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chtu_ctrl - sequencer for the coalesced hash table unit
// Steps through clearing, home slot computation, lookup, probe and chain
// append, issuing one datapath command per cycle unless it waits for a request or for the output register.
// ----------------------------------------------------------------------------
module chtu_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_valid_i,
  input  wire chtu_pkg::dp_stat_t stat_i,
  output logic                    s_ready_o,
  output chtu_pkg::dp_cmd_e       cmd_o
);
  import chtu_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    s_ready_o = 1'b0;
    cmd_o     = CMD_NONE;
    unique case (state_q)
      CS_CLEAR: begin
        cmd_o = CMD_CLEAR;
        if (stat_i.clr_last) state_d = CS_IDLE;
      end
      CS_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = CS_MOD;
        end
      end
      CS_MOD: begin
        cmd_o = CMD_MOD;
        if (stat_i.mod_last) state_d = CS_LK_RD;
      end
      CS_LK_RD: begin
        cmd_o   = CMD_LK_RD;
        state_d = CS_LK_CHK;
      end
      CS_LK_CHK: begin
        cmd_o = CMD_LK_CHK;
        if (stat_i.lk_hit) begin
          state_d = CS_DONE;
        end else if (stat_i.lk_end) begin
          state_d = stat_i.op_find ? CS_DONE : CS_PR_RD;
        end
      end
      CS_PR_RD: begin
        cmd_o   = CMD_PR_RD;
        state_d = CS_PR_CHK;
      end
      CS_PR_CHK: begin
        cmd_o = CMD_PR_CHK;
        if (stat_i.pr_empty) begin
          state_d = stat_i.pr_home ? CS_DONE : CS_CW_RD;
        end else if (stat_i.pr_last) begin
          state_d = CS_DONE;
        end
      end
      CS_CW_RD: begin
        cmd_o   = CMD_CW_RD;
        state_d = CS_CW_CHK;
      end
      CS_CW_CHK: begin
        cmd_o = CMD_CW_CHK;
        if (stat_i.cw_end) state_d = CS_DONE;
      end
      CS_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o   = CMD_EMIT;
          state_d = CS_IDLE;
        end
      end
      default: state_d = CS_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/chtu_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chtu_dp - datapath of the coalesced hash table unit
// Slot memories, reciprocal remainder unit, chain/probe pointers, result and
// output registers.
// ----------------------------------------------------------------------------
module chtu_dp #(
  parameter int TABLE_SLOTS = chtu_pkg::DEF_TABLE_SLOTS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire chtu_pkg::dp_cmd_e             cmd_i,
  input  wire logic                          op_i,
  input  wire logic [chtu_pkg::KEY_W-1:0]    key_i,
  input  wire logic                          m_ready_i,
  output chtu_pkg::dp_stat_t                 stat_o,
  output logic                               m_valid_o,
  output logic [chtu_pkg::STATUS_W-1:0]      m_status_o,
  output logic [chtu_pkg::IDX_W-1:0]         m_idx_o
);
  import chtu_pkg::*;

  localparam int IW  = $clog2(TABLE_SLOTS);
  localparam int LW  = $clog2(TABLE_SLOTS + 1);
  localparam int MCW = 1;
  localparam int RS  = KEY_W + $clog2(TABLE_SLOTS);
  localparam int RW  = KEY_W + 1;
  localparam int PW  = KEY_W + RW;
  localparam logic [IW-1:0]  LastSlot = IW'(TABLE_SLOTS - 1);
  localparam logic [LW-1:0]  LinkNone = LW'(TABLE_SLOTS);
  localparam logic [MCW-1:0] ModLast  = MCW'(1);
  // ceil(2^RS / TABLE_SLOTS): exact quotient for every KEY_W-bit key
  localparam logic [RW-1:0]  Recip    = RW'(((64'd1 << RS) + 64'(TABLE_SLOTS) - 64'd1) /
                                            64'(TABLE_SLOTS));

  function automatic logic [IDX_W-1:0] to_idx(input logic [IW-1:0] v);
    logic [63:0] e;
    e = 64'(v);
    return e[IDX_W-1:0];
  endfunction

  // slot memories
  logic [KEY_W-1:0] key_mem  [TABLE_SLOTS];
  logic             used_mem [TABLE_SLOTS];
  logic [LW-1:0]    link_mem [TABLE_SLOTS];

  logic [IW-1:0]    raddr, waddr;
  logic             we_key, we_used, we_link, wused;
  logic [LW-1:0]    wlink;
  logic             rd_used_q;
  logic [KEY_W-1:0] rd_key_q;
  logic [LW-1:0]    rd_link_q;

  // request and walk registers
  logic             op_q;
  logic [KEY_W-1:0] key_q;
  logic [PW-1:0]    prod_q;
  logic [MCW-1:0]   mcnt_q;
  logic [IW-1:0]    rem_q, cur_q, pos_q, cnt_q;
  status_e          res_status_q;
  logic [IDX_W-1:0] res_idx_q;
  logic             m_valid_q;
  logic [STATUS_W-1:0] m_status_q;
  logic [IDX_W-1:0] m_idx_q;

  logic [KEY_W-1:0] quo, qn;
  logic             hit, link_none, cnt_last;
  logic [IW-1:0]    link_idx, pos_next;

  // home slot: quotient by reciprocal multiply, remainder from its low bits
  assign quo = KEY_W'(prod_q >> RS);
  assign qn  = quo * KEY_W'(TABLE_SLOTS);

  assign hit       = rd_used_q && (rd_key_q == key_q);
  assign link_none = (rd_link_q >= LinkNone);
  assign link_idx  = rd_link_q[IW-1:0];
  assign cnt_last  = (cnt_q == LastSlot);
  assign pos_next  = (pos_q == LastSlot) ? '0 : pos_q + 1'b1;

  always_comb begin
    stat_o.clr_last = cnt_last;
    stat_o.mod_last = (mcnt_q == ModLast);
    stat_o.lk_hit   = hit;
    stat_o.lk_end   = !hit && (link_none || cnt_last);
    stat_o.op_find  = op_q;
    stat_o.pr_empty = !rd_used_q;
    stat_o.pr_home  = (pos_q == rem_q);
    stat_o.pr_last  = cnt_last;
    stat_o.cw_end   = link_none || cnt_last;
    stat_o.out_busy = m_valid_q && !m_ready_i;
  end

  // memory address and write control
  always_comb begin
    raddr   = cur_q;
    waddr   = pos_q;
    we_key  = 1'b0;
    we_used = 1'b0;
    we_link = 1'b0;
    wused   = 1'b0;
    wlink   = LinkNone;
    case (cmd_i)
      CMD_CLEAR: begin
        waddr   = cnt_q;
        we_used = 1'b1;
        we_link = 1'b1;
      end
      CMD_LK_RD, CMD_PR_RD, CMD_CW_RD: raddr = rem_q;
      CMD_LK_CHK: begin
        if (!hit && !link_none && !cnt_last) raddr = link_idx;
      end
      CMD_PR_CHK: begin
        if (!rd_used_q) begin
          waddr   = pos_q;
          we_key  = 1'b1;
          we_used = 1'b1;
          we_link = 1'b1;
          wused   = 1'b1;
        end else if (!cnt_last) begin
          raddr = pos_next;
        end
      end
      CMD_CW_CHK: begin
        wlink = LW'(pos_q);
        if (link_none) begin
          waddr   = cur_q;
          we_link = 1'b1;
        end else if (cnt_last) begin
          waddr   = link_idx;
          we_link = 1'b1;
        end else begin
          raddr = link_idx;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_key)  key_mem[waddr]  <= key_q;
    if (we_used) used_mem[waddr] <= wused;
    if (we_link) link_mem[waddr] <= wlink;
    rd_key_q  <= key_mem[raddr];
    rd_used_q <= used_mem[raddr];
    rd_link_q <= link_mem[raddr];
  end

  // control counters and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      mcnt_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      case (cmd_i)
        CMD_CLEAR: cnt_q <= cnt_q + 1'b1;
        CMD_LOAD:  mcnt_q <= '0;
        CMD_MOD:   mcnt_q <= mcnt_q + 1'b1;
        CMD_LK_RD, CMD_PR_RD, CMD_CW_RD: cnt_q <= '0;
        CMD_LK_CHK: if (!hit && !link_none && !cnt_last) cnt_q <= cnt_q + 1'b1;
        CMD_PR_CHK: if (rd_used_q && !cnt_last) cnt_q <= cnt_q + 1'b1;
        CMD_CW_CHK: if (!link_none && !cnt_last) cnt_q <= cnt_q + 1'b1;
        default: ;
      endcase
      if (cmd_i == CMD_EMIT) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        op_q  <= op_i;
        key_q <= key_i;
        rem_q <= '0;
      end
      // first step forms the product, second step takes the remainder
      CMD_MOD: begin
        prod_q <= PW'(key_q) * PW'(Recip);
        rem_q  <= key_q[IW-1:0] - qn[IW-1:0];
      end
      CMD_LK_RD, CMD_CW_RD: cur_q <= rem_q;
      CMD_LK_CHK: begin
        if (hit) begin
          res_status_q <= op_q ? ST_FOUND : ST_DUPLICATE;
          res_idx_q    <= op_q ? to_idx(cur_q) : '0;
        end else if (link_none || cnt_last) begin
          res_status_q <= ST_NOT_FOUND;
          res_idx_q    <= '0;
        end else begin
          cur_q <= link_idx;
        end
      end
      CMD_PR_RD: pos_q <= rem_q;
      CMD_PR_CHK: begin
        if (!rd_used_q) begin
          res_status_q <= ST_INSERTED;
          res_idx_q    <= to_idx(pos_q);
        end else if (cnt_last) begin
          res_status_q <= ST_FULL;
          res_idx_q    <= '0;
        end else begin
          pos_q <= pos_next;
        end
      end
      CMD_CW_CHK: if (!link_none && !cnt_last) cur_q <= link_idx;
      CMD_EMIT: begin
        m_status_q <= res_status_q;
        m_idx_q    <= res_idx_q;
      end
      default: ;
    endcase
  end

  assign m_valid_o  = m_valid_q;
  assign m_status_o = m_status_q;
  assign m_idx_o    = m_idx_q;

endmodule
`default_nettype wire

/* rtl/core/coalesced_hash_table_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// coalesced_hash_table_unit - hash table with coalesced chains
// Insert and find of 30-bit keys in a table of TABLE_SLOTS slots; collisions
// are resolved by linear probing for a free slot and linking it into the
// home slot's chain.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (s_axis): tuser = op (0 insert, 1 find), tdata = key.
//   Result channel (m_axis): one result per request, tdata = status and
//   slot index (slot where the key was inserted or found, else 0).
//   One request is in work at a time. From accept to result valid the unit
//   computes the home slot (key mod TABLE_SLOTS by reciprocal multiply),
//   looks the key up along the home chain, on an insert miss probes for a
//   free slot, and when the free slot is not home walks the home chain to
//   link it at the tail, then finishes. The slot memory (one read and one
//   write port) paces every chain and probe step.
//   Reset: after rst_ni rises, a clearing pass over all TABLE_SLOTS slots marks
//   every slot empty and unlinked; s_axis_tready stays low until it ends.
//   Stall: the result sits in an output register; a new request is taken
//   while it waits, but its own result is held back until the old one is
//   taken, so a stalled receiver backs up the request channel.
// ----------------------------------------------------------------------------
module coalesced_hash_table_unit #(
  parameter int TABLE_SLOTS = chtu_pkg::DEF_TABLE_SLOTS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // request channel
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [chtu_pkg::S_DATA_W-1:0]  s_axis_tdata,  // [29:0] key, [31:30] zero
  input  wire logic                           s_axis_tuser,  // [0] op
  // result channel
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [chtu_pkg::M_DATA_W-1:0]       m_axis_tdata   // [2:0] status,
                                                             // [8:3] slot_index,
                                                             // [15:9] zero
);
  import chtu_pkg::*;

  dp_cmd_e             cmd;
  dp_stat_t            stat;
  logic [STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]    res_idx;

  chtu_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .stat_i    (stat),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd)
  );

  chtu_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .op_i       (s_axis_tuser),
    .key_i      (s_axis_tdata[KEY_W-1:0]),
    .m_ready_i  (m_axis_tready),
    .stat_o     (stat),
    .m_valid_o  (m_axis_tvalid),
    .m_status_o (res_status),
    .m_idx_o    (res_idx)
  );

  // status in the low bits, slot index above, zero fill
  assign m_axis_tdata = {{(M_DATA_W - STATUS_W - IDX_W){1'b0}}, res_idx, res_status};

  // one request at a time: the unit is busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while previous one in work");

  // only defined result codes leave the unit
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:0] == ST_INSERTED ||
                       m_axis_tdata[2:0] == ST_DUPLICATE ||
                       m_axis_tdata[2:0] == ST_FULL ||
                       m_axis_tdata[2:0] == ST_FOUND ||
                       m_axis_tdata[2:0] == ST_NOT_FOUND))
    else $error("undefined result status");

  // duplicate, full and not found carry no slot
  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2:0] == ST_DUPLICATE ||
                      m_axis_tdata[2:0] == ST_FULL ||
                      m_axis_tdata[2:0] == ST_NOT_FOUND)
    |-> m_axis_tdata[8:3] == '0)
    else $error("slot index set on a result without a slot");

  // a reported slot lies inside the table
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2:0] == ST_INSERTED ||
                      m_axis_tdata[2:0] == ST_FOUND)
    |-> (TABLE_SLOTS > 64) || (int'(m_axis_tdata[8:3]) < TABLE_SLOTS))
    else $error("slot index beyond the table");

endmodule
`default_nettype wire

/* tb/chtu_table_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtu_table_checker - request/result checker for the coalesced hash table
// Watches both stream channels, keeps its own copy of the slot table, works
// out the result of every accepted request and compares it with the results
// that come back in order.
// ----------------------------------------------------------------------------
package chtu_tb_pkg;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_FIND   = 1'b1
  } table_op_e;

endpackage

module chtu_table_checker #(
  parameter int TABLE_SLOTS = chtu_pkg::DEF_TABLE_SLOTS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  input  wire logic                          s_axis_tready,
  input  wire logic [chtu_pkg::S_DATA_W-1:0] s_axis_tdata,  // [29:0] key, [31:30] zero
  input  wire logic                          s_axis_tuser,  // [0] op
  input  wire logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  input  wire logic [chtu_pkg::M_DATA_W-1:0] m_axis_tdata,  // [2:0] status,
                                                            // [8:3] slot_index,
                                                            // [15:9] zero
  output int                                 error_count_o,
  output int                                 pending_o,
  output int                                 inserted_cnt_o,
  output int                                 duplicate_cnt_o,
  output int                                 full_cnt_o,
  output int                                 found_cnt_o,
  output int                                 missing_cnt_o
);

  import chtu_pkg::*;
  import chtu_tb_pkg::*;

  localparam int NO_LINK = 63;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] slot;
  } table_result_t;

  logic [KEY_W-1:0] stored_key [TABLE_SLOTS];
  bit               slot_taken [TABLE_SLOTS];
  int               next_slot  [TABLE_SLOTS];
  table_result_t    expected_results [$];

  // Walk the chain from the home slot; TABLE_SLOTS means absent.
  function automatic int chain_lookup(input logic [KEY_W-1:0] key);
    int cur;
    int steps;
    cur = int'(key % TABLE_SLOTS);
    for (steps = 0; steps < TABLE_SLOTS && cur < TABLE_SLOTS; steps++) begin
      if (slot_taken[cur] && stored_key[cur] == key) return cur;
      cur = next_slot[cur];
    end
    return TABLE_SLOTS;
  endfunction

  // Applies one request to the table copy and returns its result.
  function automatic table_result_t apply_request(input table_op_e op,
                                                  input logic [KEY_W-1:0] key);
    table_result_t res;
    int hit;
    int home;
    int pos;
    int tail;
    int steps;
    bit placed;
    hit        = chain_lookup(key);
    home       = int'(key % TABLE_SLOTS);
    res.status = ST_NOT_FOUND;
    res.slot   = '0;
    placed     = 1'b0;
    if (op == OP_FIND) begin
      if (hit < TABLE_SLOTS) begin
        res.status = ST_FOUND;
        res.slot   = hit[IDX_W-1:0];
      end
    end else if (hit < TABLE_SLOTS) begin
      res.status = ST_DUPLICATE;
    end else begin
      res.status = ST_FULL;
      for (int i = 0; i < TABLE_SLOTS && !placed; i++) begin
        pos = (home + i) % TABLE_SLOTS;
        if (!slot_taken[pos]) begin
          stored_key[pos] = key;
          slot_taken[pos] = 1'b1;
          next_slot[pos]  = NO_LINK;
          // free slot away from home joins the tail of the home chain
          if (pos != home) begin
            tail = home;
            for (steps = 0; steps < TABLE_SLOTS && next_slot[tail] < TABLE_SLOTS;
                 steps++) begin
              tail = next_slot[tail];
            end
            next_slot[tail] = pos;
          end
          res.status = ST_INSERTED;
          res.slot   = pos[IDX_W-1:0];
          placed     = 1'b1;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    table_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        stored_key[i] = '0;
        slot_taken[i] = 1'b0;
        next_slot[i]  = NO_LINK;
      end
      expected_results.delete();
      error_count_o   = 0;
      pending_o       = 0;
      inserted_cnt_o  = 0;
      duplicate_cnt_o = 0;
      full_cnt_o      = 0;
      found_cnt_o     = 0;
      missing_cnt_o   = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: tdata %h", m_axis_tdata);
          error_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[STATUS_W-1:0] != want.status) begin
            $error("status: expected %0d, got %0d", want.status,
                   m_axis_tdata[STATUS_W-1:0]);
            error_count_o++;
          end
          if (m_axis_tdata[STATUS_W +: IDX_W] != want.slot) begin
            $error("slot_index: expected %0d, got %0d", want.slot,
                   m_axis_tdata[STATUS_W +: IDX_W]);
            error_count_o++;
          end
          case (want.status)
            ST_INSERTED:  inserted_cnt_o++;
            ST_DUPLICATE: duplicate_cnt_o++;
            ST_FULL:      full_cnt_o++;
            ST_FOUND:     found_cnt_o++;
            default:      missing_cnt_o++;
          endcase
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(apply_request(table_op_e'(s_axis_tuser),
                                                 s_axis_tdata[KEY_W-1:0]));
      end
      pending_o = expected_results.size();
    end
  end

endmodule

/* tb/tb_coalesced_hash_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_coalesced_hash_table_unit - testbench for the coalesced hash table unit
// Directed inserts and finds build coalesced chains from known keys, then
// random requests in four idle/stall phases fill the table and keep hitting
// duplicates, full table, hits and misses. A checker beside the block
// predicts every result and compares it.
// ----------------------------------------------------------------------------
module tb_coalesced_hash_table_unit;

  import chtu_pkg::*;
  import chtu_tb_pkg::*;

  localparam int RANDOM_PER_PHASE = 125;
  localparam int DRAIN_CYCLES     = 160;   // above the worst request latency
  localparam int CLUSTER_HOMES    = 8;     // crowd homes to grow long chains
  localparam int MAX_KEY_MULT     = 29020048;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tuser  = 1'b0;
  logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
  logic                  m_axis_tready = 1'b0;
  wire logic             s_axis_tready;
  wire logic             m_axis_tvalid;
  wire logic [M_DATA_W-1:0] m_axis_tdata;

  int error_count;
  int pending;
  int inserted_cnt;
  int duplicate_cnt;
  int full_cnt;
  int found_cnt;
  int missing_cnt;

  // idle/stall odds in percent, changed per phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int request_cnt    = 0;

  // every key ever offered for insert, used to aim duplicates and finds
  logic [KEY_W-1:0] offered_keys [$];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  coalesced_hash_table_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  chtu_table_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .error_count_o   (error_count),
    .pending_o       (pending),
    .inserted_cnt_o  (inserted_cnt),
    .duplicate_cnt_o (duplicate_cnt),
    .full_cnt_o      (full_cnt),
    .found_cnt_o     (found_cnt),
    .missing_cnt_o   (missing_cnt)
  );

  // Result side: ready is redrawn every falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offers one request at a falling edge after a random idle gap and holds it
  // until the rising edge that takes it. The next call (or the end) is the
  // only place valid is touched again, so it never drops between requests
  // that go back to back.
  task automatic send_request(input table_op_e op, input logic [KEY_W-1:0] key);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(S_DATA_W-KEY_W){1'b0}}, key};
    do @(posedge clk_i); while (!s_axis_tready);
    request_cnt++;
    if (op == OP_INSERT) offered_keys.push_back(key);
  endtask

  // A key whose home slot is the given one.
  function automatic logic [KEY_W-1:0] key_with_home(input int home);
    logic [31:0] mult;
    mult = $urandom_range(MAX_KEY_MULT);
    return KEY_W'(mult * DEF_TABLE_SLOTS + home);
  endfunction

  function automatic logic [KEY_W-1:0] any_key();
    return KEY_W'($urandom());
  endfunction

  // One random request. Most traffic is inserts that crowd a few homes
  // (long coalesced chains), repeated inserts and finds of known keys;
  // the rest are raw keys and near misses that share a known key's home.
  task automatic random_request();
    int pick;
    logic [KEY_W-1:0] known;
    pick = $urandom_range(99);
    known = offered_keys[$urandom_range(offered_keys.size() - 1)];
    if (pick < 10) begin
      send_request(OP_INSERT, key_with_home($urandom_range(CLUSTER_HOMES - 1)));
    end else if (pick < 14) begin
      send_request(OP_INSERT, key_with_home($urandom_range(DEF_TABLE_SLOTS - 1)));
    end else if (pick < 19) begin
      send_request(OP_INSERT, any_key());
    end else if (pick < 34) begin
      send_request(OP_INSERT, known);
    end else if (pick < 66) begin
      send_request(OP_FIND, known);
    end else if (pick < 80) begin
      send_request(OP_FIND, any_key());
    end else begin
      send_request(OP_FIND, key_with_home(int'(known % DEF_TABLE_SLOTS)));
    end
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: key zero on an empty table, a chain at home 0 that
    // coalesces with home 1, a miss walking the whole chain, the largest
    // key, the last home slot and alternating bit patterns.
    send_request(OP_FIND,   KEY_W'(0));
    send_request(OP_INSERT, KEY_W'(0));
    send_request(OP_FIND,   KEY_W'(0));
    send_request(OP_INSERT, KEY_W'(0));
    send_request(OP_INSERT, KEY_W'(37));
    send_request(OP_INSERT, KEY_W'(1));
    send_request(OP_INSERT, KEY_W'(74));
    send_request(OP_FIND,   KEY_W'(74));
    send_request(OP_FIND,   KEY_W'(1));
    send_request(OP_FIND,   KEY_W'(111));
    send_request(OP_INSERT, KEY_W'(2));
    send_request(OP_FIND,   KEY_W'(2));
    send_request(OP_INSERT, {KEY_W{1'b1}});
    send_request(OP_FIND,   {KEY_W{1'b1}});
    send_request(OP_INSERT, {KEY_W{1'b1}});
    send_request(OP_FIND,   KEY_W'(36));
    send_request(OP_INSERT, KEY_W'(36));
    send_request(OP_INSERT, KEY_W'(73));
    send_request(OP_FIND,   KEY_W'(73));
    send_request(OP_INSERT, KEY_W'(30'h2AAA_AAAA));
    send_request(OP_INSERT, KEY_W'(30'h1555_5555));
    send_request(OP_FIND,   KEY_W'(30'h2AAA_AAAA));
    send_request(OP_FIND,   KEY_W'(30'h1555_5555));

    // Random part in phases: sender idle, receiver stall, both, none.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 48; recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 0;  recv_stall_pct = 48; end
        2:       begin send_idle_pct = 6;  recv_stall_pct = 6;  end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      repeat (RANDOM_PER_PHASE) random_request();
    end

    // Drain: free running receiver, then wait out the block's latency so a
    // stray extra result would still be seen by the checker.
    recv_stall_pct = 0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d requests over four idle/stall phases, table filled to the end",
             request_cnt);
    $display("results: %0d inserted, %0d duplicate, %0d full, %0d found, %0d not found",
             inserted_cnt, duplicate_cnt, full_cnt, found_cnt, missing_cnt);
    if (error_count == 0) begin
      $display("tb_coalesced_hash_table_unit: done, clean");
    end else begin
      $display("tb_coalesced_hash_table_unit: done, errors");
    end
    $finish;
  end

  // Hang guard, several times the slowest legal run.
  initial begin
    #10_000_000;
    $display("tb_coalesced_hash_table_unit: done, errors");
    $finish;
  end

endmodule
